// ===== rtl/sbcr_pkg.sv =====
// Shared types, codes and constants for the segment bar renderer.
`timescale 1ns / 1ps

package sbcr_pkg;

  // Field and register widths
  localparam int STRIP_W    = 10;
  localparam int SEG_CNT_W  = 5;
  localparam int GAP_W      = 4;
  localparam int MODE_W     = 2;
  localparam int WIN_W      = 5;
  localparam int CMD_W      = 2;
  localparam int PIX_W      = 10;
  localparam int RND_W      = 16;
  localparam int SEG_IDX_W  = 4;
  localparam int LEVEL_W    = 5;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Segment limit and divider sizing
  localparam int MAX_SEGMENTS = 16;
  localparam int DIV_BITS     = STRIP_W;
  localparam int DIV_CNT_W    = $clog2(DIV_BITS);

  // Register values after reset
  localparam logic [STRIP_W-1:0]   STRIP_LENGTH_RST  = 10'd60;
  localparam logic [SEG_CNT_W-1:0] SEGMENT_COUNT_RST = 5'd8;
  localparam logic [GAP_W-1:0]     GAP_PIXELS_RST    = 4'd3;
  localparam logic [WIN_W-1:0]     WINDOW_WIDTH_RST  = 5'd2;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_STEP  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Display modes
  typedef enum logic [MODE_W-1:0] {
    MODE_FILL_UP   = 2'd0,
    MODE_FILL_DOWN = 2'd1,
    MODE_RANDOM    = 2'd2,
    MODE_WINDOW    = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIP_LENGTH  = 3'd0,
    REG_SEGMENT_COUNT = 3'd1,
    REG_GAP_PIXELS    = 3'd2,
    REG_DISPLAY_MODE  = 3'd3,
    REG_WINDOW_WIDTH  = 3'd4
  } reg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic prep;
    logic div_step;
    logic walk_step;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic beyond;
    logic div_last;
    logic walk_found;
  } dp_sts_t;

endpackage

// ===== rtl/sbcr_ctrl.sv =====
// Controller state machine sequencing each request through the datapath.
`timescale 1ns / 1ps

module sbcr_ctrl
  import sbcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  output logic             out_valid,
  input  logic             out_ready,
  output dp_cmd_t          dp_cmd,
  input  dp_sts_t          dp_sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load_item = 1'b1;
          state_nxt = (in_command == CMD_QUERY) ? ST_PREP : ST_DONE;
        end
      end
      ST_PREP: begin
        dp_cmd.prep = 1'b1;
        state_nxt = dp_sts.beyond ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        dp_cmd.div_step = 1'b1;
        if (dp_sts.div_last) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        dp_cmd.walk_step = 1'b1;
        if (dp_sts.walk_found) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.commit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The output register fills on commit and empties when the result is taken
  always_comb begin
    if (dp_cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/sbcr_dp.sv =====
// Datapath: configuration, display state, segment divider, segment walk and result register.
`timescale 1ns / 1ps

module sbcr_dp
  import sbcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [PIX_W-1:0]      in_pixel_index,
  input  logic [RND_W-1:0]      in_random_word,
  output logic                  out_pixel_lit,
  output logic                  out_in_gap,
  output logic [SEG_IDX_W-1:0]  out_segment_index,
  output logic [LEVEL_W-1:0]    out_fill_level,
  output logic                  out_hold_full,
  output logic                  out_new_color,
  input  dp_cmd_t               dp_cmd,
  output dp_sts_t               dp_sts
);

  // Configuration registers
  logic [STRIP_W-1:0]   strip_length_r;
  logic [SEG_CNT_W-1:0] segment_count_r;
  logic [GAP_W-1:0]     gap_pixels_r;
  logic [MODE_W-1:0]    display_mode_r;
  logic [WIN_W-1:0]     window_width_r;

  // Display state
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               moving_down_r, moving_down_nxt;
  logic [MASK_W-1:0]  lit_mask_r, lit_mask_nxt;

  // Request held while it is worked on
  logic [CMD_W-1:0] cmd_r;
  logic [PIX_W-1:0] pix_r;
  logic [RND_W-1:0] rnd_r;

  // Divider and walk registers
  logic [STRIP_W-1:0]   quo_r;
  logic [SEG_CNT_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [GAP_W-1:0]     gap_eff_r;
  logic [STRIP_W:0]     pos_r;
  logic [SEG_IDX_W-1:0] seg_r;

  // Located pixel
  logic                 res_inseg_r;
  logic                 res_gap_r;
  logic [SEG_IDX_W-1:0] res_seg_r;

  // Result register
  logic                 out_pixel_lit_r;
  logic                 out_in_gap_r;
  logic [SEG_IDX_W-1:0] out_segment_index_r;
  logic [LEVEL_W-1:0]   out_fill_level_r;
  logic                 out_hold_full_r;
  logic                 out_new_color_r;

  // Effective segment count, clamped to one through the maximum
  logic [SEG_CNT_W-1:0] seg_k;
  always_comb begin
    if (segment_count_r == '0) begin
      seg_k = SEG_CNT_W'(1);
    end else if (segment_count_r > SEG_CNT_W'(MAX_SEGMENTS)) begin
      seg_k = SEG_CNT_W'(MAX_SEGMENTS);
    end else begin
      seg_k = segment_count_r;
    end
  end

  // Pixels left for segments once the gaps are taken out
  logic [SEG_IDX_W-1:0]         k_minus_1;
  logic [GAP_W+SEG_IDX_W-1:0]   gap_total;
  logic signed [STRIP_W:0]      avail_s;
  logic                         drop_gaps;
  logic                         beyond;
  assign k_minus_1 = SEG_IDX_W'(seg_k - SEG_CNT_W'(1));
  assign gap_total = gap_pixels_r * k_minus_1;
  assign avail_s   = $signed({1'b0, strip_length_r}) -
                     $signed({{(STRIP_W+1-GAP_W-SEG_IDX_W){1'b0}}, gap_total});
  assign drop_gaps = avail_s < $signed({{(STRIP_W+1-SEG_CNT_W){1'b0}}, seg_k});
  assign beyond    = pix_r >= strip_length_r;

  // One restoring division step per cycle
  logic [SEG_CNT_W:0] div_trial;
  logic               div_bit;
  assign div_trial = {rem_r, quo_r[STRIP_W-1]};
  assign div_bit   = div_trial >= {1'b0, seg_k};

  // Segment walk: length of the current segment and the end of it and its gap
  logic             extra_px;
  logic [STRIP_W:0] seg_len;
  logic [STRIP_W:0] seg_end;
  logic [STRIP_W:0] gap_end;
  logic [STRIP_W:0] pix_ext;
  logic             hit_seg;
  logic             hit_gap;
  logic             last_seg;
  assign extra_px = {1'b0, seg_r} < rem_r;
  assign seg_len  = {1'b0, quo_r} + {{STRIP_W{1'b0}}, extra_px};
  assign seg_end  = pos_r + seg_len;
  assign gap_end  = seg_end + {{(STRIP_W+1-GAP_W){1'b0}}, gap_eff_r};
  assign pix_ext  = {{(STRIP_W+1-PIX_W){1'b0}}, pix_r};
  assign hit_seg  = pix_ext < seg_end;
  assign hit_gap  = !hit_seg && (pix_ext < gap_end);
  assign last_seg = {1'b0, seg_r} == (seg_k - SEG_CNT_W'(1));

  assign dp_sts.beyond     = beyond;
  assign dp_sts.div_last   = div_cnt_r == DIV_CNT_W'(DIV_BITS - 1);
  assign dp_sts.walk_found = hit_seg || hit_gap || last_seg;

  // Lighting rule for the located segment
  logic [SEG_CNT_W:0] seg_plus_level;
  logic [SEG_CNT_W:0] win_end;
  logic               seg_lit;
  assign seg_plus_level = {2'b00, res_seg_r} + {1'b0, level_r};
  assign win_end        = {1'b0, level_r} + {1'b0, window_width_r};
  always_comb begin
    unique case (mode_t'(display_mode_r))
      MODE_FILL_UP:   seg_lit = {1'b0, res_seg_r} < level_r;
      MODE_FILL_DOWN: seg_lit = seg_plus_level >= {1'b0, seg_k};
      MODE_RANDOM:    seg_lit = lit_mask_r[res_seg_r];
      MODE_WINDOW:    seg_lit = ({1'b0, res_seg_r} >= level_r) &&
                                ({2'b00, res_seg_r} < win_end);
      default:        seg_lit = 1'b0;
    endcase
  end

  // Sliding window bounds and the moved position
  logic [WIN_W-1:0]       win_w;
  logic [SEG_CNT_W-1:0]   win_max;
  logic signed [LEVEL_W+1:0] win_pos;
  assign win_w   = (window_width_r > seg_k) ? seg_k : window_width_r;
  assign win_max = seg_k - win_w;
  assign win_pos = moving_down_r ? ($signed({2'b00, level_r}) - 7'sd1)
                                 : ($signed({2'b00, level_r}) + 7'sd1);

  // Next display state and step flags for the held request
  logic hold_flag, fresh_flag;
  always_comb begin
    level_nxt       = level_r;
    moving_down_nxt = moving_down_r;
    lit_mask_nxt    = lit_mask_r;
    hold_flag       = 1'b0;
    fresh_flag      = 1'b0;
    if (cmd_r == CMD_STEP) begin
      unique case (mode_t'(display_mode_r))
        MODE_RANDOM: lit_mask_nxt = rnd_r;
        MODE_WINDOW: begin
          if (win_pos >= $signed({2'b00, win_max})) begin
            level_nxt       = win_max;
            moving_down_nxt = 1'b1;
          end else if (win_pos <= 7'sd0) begin
            level_nxt       = '0;
            moving_down_nxt = 1'b0;
          end else begin
            level_nxt = win_pos[LEVEL_W-1:0];
          end
        end
        MODE_FILL_UP, MODE_FILL_DOWN: begin
          if (level_r >= seg_k) begin
            level_nxt  = '0;
            fresh_flag = 1'b1;
          end else begin
            level_nxt = level_r + LEVEL_W'(1);
            hold_flag = (level_r + LEVEL_W'(1)) >= seg_k;
          end
        end
        default: level_nxt = level_r;
      endcase
    end else if (cmd_r == CMD_CLEAR) begin
      level_nxt       = '0;
      moving_down_nxt = 1'b0;
      lit_mask_nxt    = '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_length_r  <= STRIP_LENGTH_RST;
      segment_count_r <= SEGMENT_COUNT_RST;
      gap_pixels_r    <= GAP_PIXELS_RST;
      display_mode_r  <= MODE_FILL_UP;
      window_width_r  <= WINDOW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STRIP_LENGTH:  strip_length_r  <= cfg_wdata[STRIP_W-1:0];
        REG_SEGMENT_COUNT: segment_count_r <= cfg_wdata[SEG_CNT_W-1:0];
        REG_GAP_PIXELS:    gap_pixels_r    <= cfg_wdata[GAP_W-1:0];
        REG_DISPLAY_MODE:  display_mode_r  <= cfg_wdata[MODE_W-1:0];
        REG_WINDOW_WIDTH:  window_width_r  <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Display state, updated when a request completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r       <= '0;
      moving_down_r <= 1'b0;
      lit_mask_r    <= '0;
    end else if (dp_cmd.commit) begin
      level_r       <= level_nxt;
      moving_down_r <= moving_down_nxt;
      lit_mask_r    <= lit_mask_nxt;
    end
  end

  // Request capture, divider, walk and located pixel
  always_ff @(posedge clk) begin
    if (dp_cmd.load_item) begin
      cmd_r <= in_command;
      pix_r <= in_pixel_index;
      rnd_r <= in_random_word;
    end
    if (dp_cmd.prep) begin
      quo_r       <= drop_gaps ? strip_length_r : avail_s[STRIP_W-1:0];
      gap_eff_r   <= drop_gaps ? '0 : gap_pixels_r;
      rem_r       <= '0;
      div_cnt_r   <= '0;
      pos_r       <= '0;
      seg_r       <= '0;
      res_inseg_r <= 1'b0;
      res_gap_r   <= 1'b0;
      res_seg_r   <= '0;
    end
    if (dp_cmd.div_step) begin
      rem_r     <= div_bit ? SEG_CNT_W'(div_trial - {1'b0, seg_k})
                           : div_trial[SEG_CNT_W-1:0];
      quo_r     <= {quo_r[STRIP_W-2:0], div_bit};
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
    if (dp_cmd.walk_step) begin
      if (hit_seg || hit_gap) begin
        res_inseg_r <= hit_seg;
        res_gap_r   <= hit_gap;
        res_seg_r   <= seg_r;
      end else begin
        pos_r <= gap_end;
        seg_r <= seg_r + SEG_IDX_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      out_fill_level_r <= level_nxt;
      out_hold_full_r  <= hold_flag;
      out_new_color_r  <= fresh_flag;
      if (cmd_r == CMD_QUERY) begin
        out_pixel_lit_r     <= res_inseg_r && seg_lit;
        out_in_gap_r        <= res_gap_r;
        out_segment_index_r <= res_seg_r;
      end else begin
        out_pixel_lit_r     <= 1'b0;
        out_in_gap_r        <= 1'b0;
        out_segment_index_r <= '0;
      end
    end
  end

  assign out_pixel_lit     = out_pixel_lit_r;
  assign out_in_gap        = out_in_gap_r;
  assign out_segment_index = out_segment_index_r;
  assign out_fill_level    = out_fill_level_r;
  assign out_hold_full     = out_hold_full_r;
  assign out_new_color     = out_new_color_r;

endmodule

// ===== rtl/segment_bar_counter_renderer_unit.sv =====
// Top level of the segment bar renderer: controller and datapath.
`timescale 1ns / 1ps

// Renders a segmented bar on one LED strip and answers one request at a time.
// Step, clear and unknown requests go from acceptance straight to the done
// state. A pixel query passes through a prepare state, a bit-serial division of
// the usable pixel count by the segment count, and a walk over the segments, one
// segment per cycle, until the pixel is found (1 to 16 segments); a pixel beyond
// the strip skips the division and the walk. The next request is accepted once
// the previous one has left the datapath, even while its result still sits in
// the output register; a result waits in the done state until that register is
// free or being emptied. Configuration registers are written through cfg_we,
// cfg_index and cfg_wdata and should only change while the block is idle.
module segment_bar_counter_renderer_unit
  import sbcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [PIX_W-1:0]      in_pixel_index,
  input  logic [RND_W-1:0]      in_random_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_pixel_lit,
  output logic                  out_in_gap,
  output logic [SEG_IDX_W-1:0]  out_segment_index,
  output logic [LEVEL_W-1:0]    out_fill_level,
  output logic                  out_hold_full,
  output logic                  out_new_color
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Request sequencing
  sbcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dp_cmd     (dp_cmd),
    .dp_sts     (dp_sts)
  );

  // Registers, divider, segment walk and result
  sbcr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_command),
    .in_pixel_index    (in_pixel_index),
    .in_random_word    (in_random_word),
    .out_pixel_lit     (out_pixel_lit),
    .out_in_gap        (out_in_gap),
    .out_segment_index (out_segment_index),
    .out_fill_level    (out_fill_level),
    .out_hold_full     (out_hold_full),
    .out_new_color     (out_new_color),
    .dp_cmd            (dp_cmd),
    .dp_sts            (dp_sts)
  );

endmodule

// ===== test/sbcr_bar_checker.sv =====
// Result checker for the segment bar renderer: tracks registers, predicts and compares.
`timescale 1ns / 1ps

module sbcr_bar_checker
  import sbcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [PIX_W-1:0]      in_pixel_index,
  input  logic [RND_W-1:0]      in_random_word,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_pixel_lit,
  input  logic                  out_in_gap,
  input  logic [SEG_IDX_W-1:0]  out_segment_index,
  input  logic [LEVEL_W-1:0]    out_fill_level,
  input  logic                  out_hold_full,
  input  logic                  out_new_color,
  output int unsigned           failures,
  output int unsigned           outstanding,
  output int unsigned           results_seen
);

  // One result of the block, in port order.
  typedef struct packed {
    logic                 lit;
    logic                 gap;
    logic [SEG_IDX_W-1:0] seg;
    logic [LEVEL_W-1:0]   level;
    logic                 hold;
    logic                 fresh;
  } bar_result_t;

  // Where a pixel falls on the strip.
  typedef enum {PIX_BEYOND, PIX_SEGMENT, PIX_GAP} pix_place_t;

  // Shadow copies of the registers and of the display state.
  logic [STRIP_W-1:0]   strip_q;
  logic [SEG_CNT_W-1:0] seg_cnt_q;
  logic [GAP_W-1:0]     gap_q;
  mode_t                mode_q;
  logic [WIN_W-1:0]     win_q;
  logic [LEVEL_W-1:0]   level_q;
  logic                 sliding_down;
  logic [MASK_W-1:0]    mask_q;

  bar_result_t expected_q[$];

  // Segment count as the block uses it, clamped to 1 .. MAX_SEGMENTS.
  function automatic int used_segments();
    if (seg_cnt_q == '0) return 1;
    if (int'(seg_cnt_q) > MAX_SEGMENTS) return MAX_SEGMENTS;
    return int'(seg_cnt_q);
  endfunction

  // Lighting rule of the current display mode for one segment.
  function automatic logic segment_lit(input int seg, input int k);
    int lv;
    lv = int'(level_q);
    case (mode_q)
      MODE_FILL_UP:   return seg < lv;
      MODE_FILL_DOWN: return seg + lv >= k;
      MODE_RANDOM:    return seg < MASK_W && mask_q[seg];
      default:        return seg >= lv && seg < lv + int'(win_q);
    endcase
  endfunction

  // Walks the segments to find the pixel. Gaps are dropped when the strip is
  // too short for them, and spare pixels go one each to the first segments.
  function automatic pix_place_t find_pixel(input int pix, input int k, output int seg);
    int n, gap, avail, base, extra, pos, len;
    n     = int'(strip_q);
    gap   = int'(gap_q);
    avail = n - gap * (k - 1);
    seg   = 0;
    if (pix >= n) return PIX_BEYOND;
    if (avail < k) begin
      avail = n;
      gap   = 0;
    end
    base  = avail / k;
    extra = avail % k;
    pos   = 0;
    for (int i = 0; i < k; i++) begin
      len = base + ((i < extra) ? 1 : 0);
      if (pix >= pos && pix < pos + len) begin
        seg = i;
        return PIX_SEGMENT;
      end
      if (i < k - 1 && pix >= pos + len && pix < pos + len + gap) begin
        seg = i;
        return PIX_GAP;
      end
      pos += len + gap;
    end
    return PIX_BEYOND;
  endfunction

  // Applies one request to the shadow state and returns the result it should give.
  function automatic bar_result_t render_request(input logic [CMD_W-1:0] cmd,
                                                 input logic [PIX_W-1:0] pix,
                                                 input logic [RND_W-1:0] word);
    bar_result_t res;
    int k, w, span_max, lv, seg;
    pix_place_t place;
    res = '0;
    k   = used_segments();
    seg = 0;
    if (cmd == CMD_STEP) begin
      case (mode_q)
        MODE_RANDOM: mask_q = word;
        MODE_WINDOW: begin
          // The window bounces between the two ends of the bar.
          w = int'(win_q);
          if (w > k) w = k;
          span_max = k - w;
          lv = int'(level_q) + (sliding_down ? -1 : 1);
          if (lv >= span_max) begin
            lv = span_max;
            sliding_down = 1'b1;
          end else if (lv <= 0) begin
            lv = 0;
            sliding_down = 1'b0;
          end
          level_q = lv[LEVEL_W-1:0];
        end
        default: begin
          // Fill modes: wrap to empty once full, else grow by one segment.
          if (int'(level_q) >= k) begin
            level_q   = '0;
            res.fresh = 1'b1;
          end else begin
            level_q = level_q + 1'b1;
            if (int'(level_q) >= k) res.hold = 1'b1;
          end
        end
      endcase
    end else if (cmd == CMD_QUERY) begin
      place = find_pixel(int'(pix), k, seg);
      if (place == PIX_SEGMENT) res.lit = segment_lit(seg, k);
      else if (place == PIX_GAP) res.gap = 1'b1;
      res.seg = seg[SEG_IDX_W-1:0];
    end else if (cmd == CMD_CLEAR) begin
      level_q      = '0;
      sliding_down = 1'b0;
      mask_q       = '0;
    end
    res.level = level_q;
    return res;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Watch the three ports at every edge.
  always @(posedge clk) begin : watch
    bar_result_t want, got;
    if (!rst_n) begin
      strip_q      = STRIP_LENGTH_RST;
      seg_cnt_q    = SEGMENT_COUNT_RST;
      gap_q        = GAP_PIXELS_RST;
      mode_q       = MODE_FILL_UP;
      win_q        = WINDOW_WIDTH_RST;
      level_q      = '0;
      sliding_down = 1'b0;
      mask_q       = '0;
      failures     = 0;
      expected_q.delete();
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STRIP_LENGTH:  strip_q   = cfg_wdata[STRIP_W-1:0];
          REG_SEGMENT_COUNT: seg_cnt_q = cfg_wdata[SEG_CNT_W-1:0];
          REG_GAP_PIXELS:    gap_q     = cfg_wdata[GAP_W-1:0];
          REG_DISPLAY_MODE:  mode_q    = mode_t'(cfg_wdata[MODE_W-1:0]);
          REG_WINDOW_WIDTH:  win_q     = cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(render_request(in_command, in_pixel_index, in_random_word));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        got = {out_pixel_lit, out_in_gap, out_segment_index, out_fill_level,
               out_hold_full, out_new_color};
        if (expected_q.size() == 0) begin
          $error("result arrived with no request waiting for it");
          failures++;
        end else begin
          want = expected_q.pop_front();
          compare_field("pixel_lit", want.lit, got.lit);
          compare_field("in_gap", want.gap, got.gap);
          compare_field("segment_index", want.seg, got.seg);
          compare_field("fill_level", want.level, got.level);
          compare_field("hold_full", want.hold, got.hold);
          compare_field("new_color", want.fresh, got.fresh);
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== test/tb_segment_bar_counter_renderer_unit.sv =====
// Testbench top for the segment bar renderer: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_segment_bar_counter_renderer_unit;
  import sbcr_pkg::*;

  // Command code with no meaning to the block.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'b11;
  localparam int PIX_TOP        = (1 << PIX_W) - 1;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASES         = 11;
  localparam int PHASE_ITEMS    = 150;
  localparam int BACKLOG_AT     = 400;
  localparam int BACKLOG_CYCLES = 400;

  bit                    clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command;
  logic [PIX_W-1:0]      in_pixel_index;
  logic [RND_W-1:0]      in_random_word;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_pixel_lit;
  logic                  out_in_gap;
  logic [SEG_IDX_W-1:0]  out_segment_index;
  logic [LEVEL_W-1:0]    out_fill_level;
  logic                  out_hold_full;
  logic                  out_new_color;
  int unsigned           failures;
  int unsigned           outstanding;
  int unsigned           results_seen;

  // Set for phases that run with no idling on either side.
  bit calm;

  segment_bar_counter_renderer_unit dut (.*);
  sbcr_bar_checker bar_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request after an optional gap and waits until it is taken.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input int unsigned pix,
                              input logic [RND_W-1:0] word);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_pixel_index <= pix[PIX_W-1:0];
    in_random_word <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random request, with most pixel queries landing on the strip.
  task automatic send_random_request(input int unsigned strip);
    int r;
    logic [CMD_W-1:0] cmd;
    int unsigned pix;
    r = $urandom_range(0, 99);
    if (r < 45) cmd = CMD_STEP;
    else if (r < 92) cmd = CMD_QUERY;
    else if (r < 97) cmd = CMD_CLEAR;
    else cmd = CMD_UNUSED;
    if (strip > 0 && $urandom_range(0, 99) < 85) pix = $urandom_range(0, strip - 1);
    else pix = $urandom_range(0, PIX_TOP);
    send_request(cmd, pix, RND_W'($urandom));
  endtask

  // Stops offering and waits until every result has come back and the block is quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers on consecutive edges.
  task automatic program_display(input int unsigned strip, input int unsigned segs,
                                 input int unsigned gap, input mode_t mode,
                                 input int unsigned win);
    reg_idx_t    order [5];
    int unsigned value [5];
    order = '{REG_STRIP_LENGTH, REG_SEGMENT_COUNT, REG_GAP_PIXELS, REG_DISPLAY_MODE,
              REG_WINDOW_WIDTH};
    value = '{strip, segs, gap, int'(mode), win};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= value[i][CFG_DATA_W-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off to back the block up.
  initial begin : result_sink
    int stall;
    bit backlog_done;
    out_ready <= 1'b0;
    backlog_done = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!backlog_done && results_seen >= BACKLOG_AT) begin
        backlog_done = 1'b1;
        out_ready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
      end
      stall = pick_pause();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned strip, segs, gap, win;
    mode_t mode;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_STRIP_LENGTH;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_command     <= CMD_STEP;
    in_pixel_index <= '0;
    in_random_word <= '0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests on the reset settings: 60 pixels, 8 segments, 3-pixel gaps.
    send_request(CMD_QUERY, 0, '0);
    send_request(CMD_QUERY, 5, '0);
    send_request(CMD_QUERY, 59, '0);
    send_request(CMD_QUERY, 60, '0);
    send_request(CMD_QUERY, PIX_TOP, '1);
    send_request(CMD_UNUSED, 0, '1);
    // Fill to the top; the eighth step reports the hold.
    repeat (8) send_request(CMD_STEP, 0, '0);
    send_request(CMD_QUERY, 30, '0);
    // The next step wraps to empty and asks for a new colour.
    send_request(CMD_STEP, 0, '0);
    send_request(CMD_STEP, 0, '1);
    send_request(CMD_CLEAR, 0, '0);
    send_request(CMD_QUERY, 0, '0);
    wait_idle();

    // Strip too short for its gaps: they are dropped and spare pixels go first.
    program_display(10, 16, 15, MODE_RANDOM, 16);
    send_request(CMD_STEP, 0, 16'h8001);
    send_request(CMD_QUERY, 0, '0);
    send_request(CMD_QUERY, 9, '0);
    wait_idle();

    // Random phases, each on its own settings; the level carries across phases.
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph % 4 == 3);
      case (ph)
        0: begin
          strip = 1023; segs = 16; gap = 15; mode = MODE_FILL_UP; win = 16;
        end
        1: begin
          strip = 1; segs = 1; gap = 0; mode = MODE_FILL_DOWN; win = 1;
        end
        2: begin
          strip = $urandom_range(1, 200); segs = $urandom_range(1, 16);
          gap = $urandom_range(0, 15); mode = MODE_RANDOM; win = $urandom_range(1, 16);
        end
        3: begin
          strip = 60; segs = 8; gap = 3; mode = MODE_WINDOW; win = 2;
        end
        4: begin
          // Empty strip and a segment count of zero.
          strip = 0; segs = 0; gap = 7; mode = MODE_FILL_UP; win = 0;
        end
        5: begin
          // Window of zero width with an oversized segment count.
          strip = $urandom_range(16, 1023); segs = 31; gap = $urandom_range(0, 15);
          mode = MODE_WINDOW; win = 0;
        end
        6: begin
          // Window wider than the bar.
          strip = $urandom_range(1, 300); segs = $urandom_range(2, 16);
          gap = $urandom_range(0, 15); mode = MODE_WINDOW; win = $urandom_range(17, 31);
        end
        7: begin
          strip = $urandom_range(1, 40); segs = $urandom_range(0, 31); gap = 15;
          mode = MODE_FILL_DOWN; win = $urandom_range(0, 31);
        end
        8: begin
          strip = $urandom_range(1, 1023); segs = $urandom_range(1, 16);
          gap = $urandom_range(0, 15); mode = MODE_RANDOM; win = $urandom_range(1, 16);
        end
        9: begin
          strip = 1023; segs = 1; gap = 0; mode = MODE_WINDOW; win = 1;
        end
        default: begin
          strip = $urandom_range(0, 1023); segs = $urandom_range(0, 31);
          gap = $urandom_range(0, 15); mode = mode_t'($urandom_range(0, 3));
          win = $urandom_range(0, 31);
        end
      endcase
      program_display(strip, segs, gap, mode, win);
      repeat (PHASE_ITEMS) send_random_request(strip);
      wait_idle();
    end

    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sbcr_pkg.sv
rtl/sbcr_ctrl.sv
rtl/sbcr_dp.sv
rtl/segment_bar_counter_renderer_unit.sv
test/sbcr_bar_checker.sv
test/tb_segment_bar_counter_renderer_unit.sv
